// ===== hdl/cfr_pkg.sv =====
package cfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CMD     = 3'd1,
    PH_XLEN    = 3'd2,
    PH_MLEN_LO = 3'd3,
    PH_MLEN_HI = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_CHECK    = 2'd1,
    CAUSE_UNKNOWN  = 2'd2
  } cause_t;

  typedef enum logic {
    CFG_MAGIC = 1'b0,
    CFG_CAP   = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] MAGIC_RESET = 8'hCD;
  localparam logic [7:0] CAP_RESET   = 8'd40;
  localparam logic [6:0] CHECK_MASK  = 7'h7F;

  localparam logic [7:0] CMD_QUERY   = 8'h71;  // 'q'
  localparam logic [7:0] CMD_VERSION = 8'h76;  // 'v'
  localparam logic [7:0] CMD_PING    = 8'h70;  // 'p'
  localparam logic [7:0] CMD_UPPER_C = 8'h43;  // 'C'
  localparam logic [7:0] CMD_UPPER_S = 8'h53;  // 'S'
  localparam logic [7:0] CMD_XFER    = 8'h78;  // 'x'
  localparam logic [7:0] CMD_UPPER_X = 8'h58;  // 'X'
  localparam logic [7:0] CMD_MEMORY  = 8'h6D;  // 'm'

endpackage

// ===== hdl/command_frame_receiver.sv =====
// Command frame receiver.
// Input channel: rx_byte with in_valid / in_stall, one received byte per
// transaction. Output channel: kind, command_code, payload_byte,
// payload_index and reject_cause with out_valid / out_stall, one result per
// transaction. Each payload byte gives a result with its index, and each frame
// ends in an accept or a reject result; magic and length bytes give none.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 request magic,
// 1 short payload cap) and cfg_data. cfg_ready is always high.
// A result appears on the outputs in the cycle after its byte is accepted.
// Throughput is one byte per cycle when not stalled: the frame state and the
// output register both update in the cycle that a byte is accepted.
// When the receiver stalls with a result held, in_stall rises and no byte is
// taken until that result leaves; a byte that gives no result still cannot
// be taken while the output register is full and stalled.
// Reset (rst, synchronous) returns to waiting for the magic byte, empties the
// output register and restores magic 0xCD and cap 40.
module command_frame_receiver
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output kind_t       kind,
  output logic [7:0]  command_code,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output cause_t      reject_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  request_magic;
  logic [7:0]  short_payload_cap;

  phase_t      phase, phase_next;
  logic [7:0]  current_command, current_command_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_taken, bytes_taken_next;
  logic [6:0]  check_accumulator, check_accumulator_next;

  logic        accept;
  logic        emit;
  kind_t       kind_next;
  logic [7:0]  byte_next;
  logic [15:0] index_next;
  cause_t      cause_next;
  logic [15:0] length_sel;
  logic [15:0] taken_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign taken_inc = bytes_taken + 16'd1;

  always_comb begin
    phase_next             = phase;
    current_command_next   = current_command;
    payload_length_next    = payload_length;
    bytes_taken_next       = bytes_taken;
    check_accumulator_next = check_accumulator;
    emit                   = 1'b0;
    kind_next              = KIND_PAYLOAD;
    byte_next              = 8'd0;
    index_next             = 16'd0;
    cause_next             = CAUSE_NONE;
    length_sel             = 16'd0;

    case (phase)
      PH_CMD: begin
        current_command_next = rx_byte;
        if (rx_byte inside {CMD_QUERY, CMD_VERSION, CMD_PING, CMD_UPPER_C,
                            CMD_UPPER_S}) begin
          check_accumulator_next = (request_magic[6:0] | rx_byte[6:0]) & CHECK_MASK;
          phase_next = PH_CHECK;
        end else if (rx_byte inside {CMD_XFER, CMD_UPPER_X}) begin
          phase_next = PH_XLEN;
        end else if (rx_byte == CMD_MEMORY) begin
          phase_next = PH_MLEN_LO;
        end else begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          kind_next  = KIND_REJECT;
          cause_next = CAUSE_UNKNOWN;
        end
      end
      PH_XLEN: begin
        // The check starts from the length as sent, not as capped.
        length_sel = {8'd0, (rx_byte < short_payload_cap) ? rx_byte : short_payload_cap};
        payload_length_next    = length_sel;
        bytes_taken_next       = 16'd0;
        check_accumulator_next = rx_byte[6:0];
        phase_next = (length_sel == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_MLEN_LO: begin
        payload_length_next = {8'd0, rx_byte};
        phase_next          = PH_MLEN_HI;
      end
      PH_MLEN_HI: begin
        length_sel = {rx_byte, payload_length[7:0]};
        payload_length_next    = length_sel;
        bytes_taken_next       = 16'd0;
        check_accumulator_next = length_sel[6:0];
        phase_next = (length_sel == 16'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        check_accumulator_next = check_accumulator | rx_byte[6:0];
        bytes_taken_next       = taken_inc;
        if (taken_inc >= payload_length) begin
          phase_next = PH_CHECK;
        end
        emit       = 1'b1;
        kind_next  = KIND_PAYLOAD;
        byte_next  = rx_byte;
        index_next = bytes_taken;
      end
      PH_CHECK: begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
        // A check byte with bit 7 set never matches.
        if (rx_byte == {1'b0, check_accumulator}) begin
          kind_next = KIND_ACCEPT;
        end else begin
          kind_next  = KIND_REJECT;
          cause_next = CAUSE_CHECK;
        end
      end
      default: begin
        phase_next = (rx_byte == request_magic) ? PH_CMD : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_magic     <= MAGIC_RESET;
      short_payload_cap <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAGIC: request_magic     <= cfg_data;
        CFG_CAP:   short_payload_cap <= cfg_data;
        default:   request_magic     <= request_magic;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      current_command   <= 8'd0;
      payload_length    <= 16'd0;
      bytes_taken       <= 16'd0;
      check_accumulator <= 7'd0;
    end else if (accept) begin
      phase             <= phase_next;
      current_command   <= current_command_next;
      payload_length    <= payload_length_next;
      bytes_taken       <= bytes_taken_next;
      check_accumulator <= check_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind          <= kind_next;
      command_code  <= current_command_next;
      payload_byte  <= byte_next;
      payload_index <= index_next;
      reject_cause  <= cause_next;
    end
  end

  // Payload phase always has at least one byte still to come.
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_taken < payload_length)
    else $error("payload phase with no bytes left");

  // A reject always carries a cause, and only a reject does.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_REJECT) == (reject_cause != CAUSE_NONE)))
    else $error("reject cause does not match kind");

  // Non-payload results carry zero data and index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && payload_index == 16'd0)
    else $error("frame result carries payload data");

  // An unknown command always sends the receiver back to waiting for magic.
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_CMD && emit |=> phase == PH_IDLE)
    else $error("unknown command did not end the frame");

endmodule
